// ----- src/bba_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and controller/datapath link types for the bitmap
// block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int MAP_BITS_DEF = 65536;
	localparam int WORD_BITS    = 64;
	localparam int WORD_SHIFT   = 6;
	localparam int BLOCK_LIMIT  = 65536;

	localparam int CNT_W     = 17;
	localparam int IDX_W     = 16;
	localparam int FUNC_W    = 3;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [FUNC_W-1:0] FUNC_INIT  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_FREE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OOB     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_METADATA_BLOCKS = 1'b1;

	localparam logic [CNT_W-1:0] TOTAL_RST = 17'd65536;
	localparam logic [CNT_W-1:0] META_RST  = 17'd0;
	localparam logic [CNT_W-1:0] COUNT_RST = 17'd65536;

	typedef struct packed {
		logic load;       // capture request
		logic sweep;      // write fill word at address, advance
		logic zero_fill;  // sweep writes zeros (power-up clear)
		logic rd;         // read map word at address
		logic next;       // advance scan address
		logic modify;     // update the word just read
		logic commit;     // update count, load response register
	} bba_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              oob;
		logic              fc_zero;
		logic              at_last;
		logic              nonfull;
		logic              out_free;
	} bba_stat_t;

endpackage
`default_nettype wire

// ----- src/bba_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bba_req_if / bba_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface bba_req_if import bba_pkg::*;;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [IDX_W-1:0]  block_index;
	logic              bit_value;

	modport source (output valid, output func, output block_index, output bit_value,
		input ready);
	modport sink (input valid, input func, input block_index, input bit_value,
		output ready);
endinterface

interface bba_rsp_if import bba_pkg::*;;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  block_number;
	logic              bit_read;
	logic [CNT_W-1:0]  free_count;
	logic [STAT_W-1:0] status;

	modport source (output valid, output block_number, output bit_read, output free_count,
		output status, input ready);
	modport sink (input valid, input block_number, input bit_read, input free_count,
		input status, output ready);
endinterface
`default_nettype wire

// ----- src/bba_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bba_datapath
// Occupancy map memory, free count, scan hint, config registers and the
// response register.
// ----------------------------------------------------------------------------
module bba_datapath import bba_pkg::*; #(
	parameter int MAP_BITS = MAP_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_wdata,
	input  wire logic [FUNC_W-1:0]    req_func,
	input  wire logic [IDX_W-1:0]     req_block_index,
	input  wire logic                 req_bit_value,
	input  wire logic                 rsp_ready,
	output logic                      rsp_valid,
	output logic [IDX_W-1:0]          rsp_block_number,
	output logic                      rsp_bit_read,
	output logic [CNT_W-1:0]          rsp_free_count,
	output logic [STAT_W-1:0]         rsp_status,
	input  wire bba_cmd_t             cmd,
	output bba_stat_t                 stat
);

	localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CAP       = (MAP_BITS < BLOCK_LIMIT) ? MAP_BITS : BLOCK_LIMIT;
	localparam logic [CNT_W-1:0] CAP_C     = CNT_W'(CAP);
	localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);
	localparam int UW = CNT_W - WORD_SHIFT;

	logic [WORD_BITS-1:0] mem [MAP_WORDS];

	logic [CNT_W-1:0]     total_q, meta_q, fc_q;
	logic [FUNC_W-1:0]    func_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 bv_q;
	logic [AW-1:0]        addr_q, hint_q;
	logic                 found_q, bit_q;
	logic [WORD_SHIFT-1:0] pos_bit_q;
	logic [WORD_BITS-1:0] rdata_q;

	logic [CNT_W-1:0]      total, used, fc_next;
	logic [UW-1:0]         used_w;
	logic [WORD_BITS-1:0]  fill, inv, low, bit_mask, mod_word;
	logic [WORD_SHIFT-1:0] lowpos, bit_sel;
	logic [AW+WORD_SHIFT-1:0] alloc_pos;
	logic                  nonfull, alloc_ok, oob, mod_we;
	logic [AW-1:0]         idx_word_in, idx_word, hint_init;
	logic [IDX_W-1:0]      blk;
	logic [STAT_W-1:0]     st;
	logic                  rd_bit;

	// effective total and blocks reserved at init
	assign total  = (total_q < CAP_C) ? total_q : CAP_C;
	assign used   = (meta_q < total) ? meta_q : total;
	assign used_w = used[CNT_W-1:WORD_SHIFT];

	assign idx_word_in = AW'(req_block_index >> WORD_SHIFT);
	assign idx_word    = AW'(idx_q >> WORD_SHIFT);
	assign bit_sel     = idx_q[WORD_SHIFT-1:0];
	assign bit_mask    = WORD_BITS'(1) << bit_sel;
	assign oob         = ({1'b0, idx_q} >= total);
	assign hint_init   = (32'(used_w) > 32'(LAST_WORD)) ? LAST_WORD : AW'(used_w);

	always_comb begin
		if (cmd.zero_fill) begin
			fill = '0;
		end else if (32'(addr_q) < 32'(used_w)) begin
			fill = '1;
		end else if (32'(addr_q) == 32'(used_w)) begin
			fill = ~({WORD_BITS{1'b1}} << used[WORD_SHIFT-1:0]);
		end else begin
			fill = '0;
		end
	end

	// lowest clear bit of the word just read
	assign inv     = ~rdata_q;
	assign low     = inv & (~inv + WORD_BITS'(1));
	assign nonfull = |inv;

	always_comb begin
		lowpos = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (low[i]) lowpos = lowpos | WORD_SHIFT'(i);
		end
	end

	assign alloc_pos = {addr_q, lowpos};
	assign alloc_ok  = nonfull && (32'(alloc_pos) < 32'(total));

	always_comb begin
		case (func_q)
			FUNC_ALLOC: mod_word = rdata_q | low;
			FUNC_FREE:  mod_word = rdata_q & ~bit_mask;
			FUNC_WRITE: mod_word = bv_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
			default:    mod_word = rdata_q;
		endcase
	end

	assign mod_we = cmd.modify && (((func_q == FUNC_ALLOC) && alloc_ok) ||
		(func_q == FUNC_FREE) || (func_q == FUNC_WRITE));

	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			mem[addr_q] <= fill;
		end else if (mod_we) begin
			mem[addr_q] <= mod_word;
		end
		if (cmd.rd) begin
			rdata_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RST;
			meta_q  <= META_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOTAL_BLOCKS:    total_q <= cfg_wdata;
				REG_METADATA_BLOCKS: meta_q  <= cfg_wdata;
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= req_func;
			idx_q  <= req_block_index;
			bv_q   <= req_bit_value;
		end
		if (cmd.modify) begin
			pos_bit_q <= lowpos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			found_q <= 1'b0;
			bit_q   <= 1'b0;
		end else if (cmd.load) begin
			found_q <= 1'b0;
			bit_q   <= 1'b0;
			case (req_func)
				FUNC_INIT:  addr_q <= '0;
				FUNC_ALLOC: addr_q <= hint_q;
				default:    addr_q <= idx_word_in;
			endcase
		end else begin
			if (cmd.sweep || cmd.next) addr_q <= addr_q + AW'(1);
			if (cmd.modify) begin
				found_q <= (func_q == FUNC_ALLOC) && alloc_ok;
				bit_q   <= rdata_q[bit_sel];
			end
		end
	end

	// every word below the hint is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q <= '0;
		end else if (cmd.commit && (func_q == FUNC_INIT)) begin
			hint_q <= hint_init;
		end else if (cmd.modify) begin
			if ((func_q == FUNC_ALLOC) && alloc_ok) begin
				hint_q <= addr_q;
			end else if (((func_q == FUNC_FREE) || ((func_q == FUNC_WRITE) && !bv_q)) &&
				(idx_word < hint_q)) begin
				hint_q <= idx_word;
			end
		end
	end

	always_comb begin
		fc_next = fc_q;
		blk     = idx_q;
		st      = STAT_OK;
		rd_bit  = 1'b0;
		case (func_q)
			FUNC_INIT: begin
				fc_next = total - used;
				blk     = '0;
			end
			FUNC_ALLOC: begin
				if (found_q) begin
					fc_next = fc_q - CNT_W'(1);
					blk     = IDX_W'({addr_q, pos_bit_q});
				end else begin
					blk = '0;
					st  = STAT_NO_FREE;
				end
			end
			FUNC_FREE: begin
				if (oob) begin
					st = STAT_OOB;
				end else if (fc_q < total) begin
					fc_next = fc_q + CNT_W'(1);
				end
			end
			FUNC_WRITE: begin
				if (oob) st = STAT_OOB;
			end
			FUNC_READ: begin
				if (oob) st = STAT_OOB;
				rd_bit = bit_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q      <= COUNT_RST;
			rsp_valid <= 1'b0;
		end else if (cmd.commit) begin
			fc_q      <= fc_next;
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_block_number <= blk;
			rsp_bit_read     <= rd_bit;
			rsp_free_count   <= fc_next;
			rsp_status       <= st;
		end
	end

	assign stat.func     = func_q;
	assign stat.oob      = oob;
	assign stat.fc_zero  = (fc_q == '0);
	assign stat.at_last  = (addr_q == LAST_WORD);
	assign stat.nonfull  = nonfull;
	assign stat.out_free = !rsp_valid || rsp_ready;

endmodule
`default_nettype wire

// ----- src/bba_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for the allocator: power-up clear, init sweep, map scan and
// read-modify-write of single map words.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	output bba_cmd_t       cmd,
	input  wire bba_stat_t stat
);

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_DECODE = 7'b0000100,
		ST_SWEEP  = 7'b0001000,
		ST_RD     = 7'b0010000,
		ST_CHECK  = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.sweep     = 1'b1;
				cmd.zero_fill = 1'b1;
				if (stat.at_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.func)
					FUNC_INIT:  state_d = ST_SWEEP;
					FUNC_ALLOC: state_d = stat.fc_zero ? ST_FINISH : ST_RD;
					FUNC_FREE, FUNC_WRITE, FUNC_READ: begin
						state_d = stat.oob ? ST_FINISH : ST_RD;
					end
					default:    state_d = ST_FINISH;
				endcase
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.at_last) state_d = ST_FINISH;
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				// a full word during allocation moves the scan on, or ends it at the last word
				if ((stat.func == FUNC_ALLOC) && !stat.nonfull) begin
					if (stat.at_last) begin
						state_d = ST_FINISH;
					end else begin
						cmd.next = 1'b1;
						state_d  = ST_RD;
					end
				end else begin
					cmd.modify = 1'b1;
					state_d    = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- src/bitmap_block_allocator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// First-fit bitmap block allocator with a free-block count.
// ----------------------------------------------------------------------------
// One request at a time, one response per request. The map lives in a
// (MAP_BITS/64, rounded up)-word by 64-bit single-port memory and every
// operation accesses it one word at a time. After reset the block clears every
// map word (MAP_WORDS, 1024 at the default size) before it raises req.ready.
// Init rewrites every word. Allocate scans from the lowest word that may hold
// a free bit (the scan hint), a memory read then a check for each word. Free
// and write bit are one read-modify-write of a single word; read bit is one
// read of a single word. Out-of-range indices, allocate with a zero count and
// unused function codes finish without touching the map. A completed response
// sits in the output register while the next request is taken; the block only
// stalls at the end of that request if rsp is not drained. Configuration
// writes take effect at once but reach the map and the count only at the next
// init.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit import bba_pkg::*; #(
	parameter int MAP_BITS = MAP_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_wdata,
	bba_req_if.sink                   req,
	bba_rsp_if.source                 rsp
);

	bba_cmd_t  cmd;
	bba_stat_t stat;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	bba_datapath #(
		.MAP_BITS (MAP_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.req_func         (req.func),
		.req_block_index  (req.block_index),
		.req_bit_value    (req.bit_value),
		.rsp_ready        (rsp.ready),
		.rsp_valid        (rsp.valid),
		.rsp_block_number (rsp.block_number),
		.rsp_bit_read     (rsp.bit_read),
		.rsp_free_count   (rsp.free_count),
		.rsp_status       (rsp.status),
		.cmd              (cmd),
		.stat             (stat)
	);

endmodule
`default_nettype wire
